// ===== design/svpg_pkg.sv =====
// Shared types and constants for the three-channel servo pulse generator.
package svpg_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int WIDTH_W     = 9;
  localparam int FRAME_W     = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_IDX_W   = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SPAN   = 2'd2;

  localparam logic [FRAME_W-1:0]  FRAME_LENGTH_RST = 16'd2000;
  localparam logic [SAMPLE_W-1:0] MIN_WIDTH_RST    = 8'd98;
  localparam logic [SAMPLE_W-1:0] WIDTH_SPAN_RST   = 8'd101;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_length;
    logic [SAMPLE_W-1:0] min_width;
    logic [SAMPLE_W-1:0] width_span;
  } cfg_t;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [2:0] servo_pins;
    logic [1:0] adc_channel;
    logic       frame_start;
  } result_t;

endpackage

// ===== design/svpg_stream_if.sv =====
// Valid/ready stream interfaces for requests and results.
interface svpg_in_if import svpg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface svpg_out_if import svpg_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] servo_pins;
  logic [1:0] adc_channel;
  logic       frame_start;

  modport source (output valid, output servo_pins, output adc_channel,
                  output frame_start, input ready);
  modport sink   (input valid, input servo_pins, input adc_channel,
                  input frame_start, output ready);
endinterface

// ===== design/three_channel_servo_pulse_generator_unit.sv =====
// Top level of the three-channel servo pulse generator.
//
// Each request on in_chan is either a converter sample (req_type 0) or one
// time tick (req_type 1), and each request yields exactly one result on
// out_chan. A sample is stored for the converter channel now selected and the
// channel advances 0,1,..,NUM_SERVOS-1,0; adc_channel reports the channel to
// convert next. Ticks run a frame counter against frame_length; at each frame
// start the servos are pulsed one after another, each for width+1 ticks with
// width = sample*width_span/255 + min_width taken when that pulse begins.
// A frame that elapses mid-sequence starts the next sequence as soon as the
// current one ends (several such frames count as one). frame_start marks the
// tick on which a sequence began. Throughput is one request per clock while
// out_chan is ready. The accepting edge loads the input register; the result
// register is loaded when the sequencer steps, which a waiting result that is
// not taken holds off; the sequencer update between the two registers is
// combinational. While a result waits, the input register can still take one
// request. Registers (APB, 32-bit data):
// 0x0 frame_length, 0x4 min_width, 0x8 width_span; write them while idle.
module three_channel_servo_pulse_generator_unit import svpg_pkg::*; #(
  parameter int NUM_SERVOS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  svpg_in_if.sink               in_chan,
  svpg_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_v_r;
  result_t res;
  result_t out_r;
  logic    out_v_r;
  logic    adv;

  svpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step the sequencer when the input register holds a request and the
  // result register is free or being emptied this cycle
  assign adv           = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || adv;

  svpg_core #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.req_type <= in_chan.req_type;
      in_item_r.sample   <= in_chan.sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.servo_pins  = out_r.servo_pins;
  assign out_chan.adc_channel = out_r.adc_channel;
  assign out_chan.frame_start = out_r.frame_start;

endmodule

// ===== design/svpg_cfg.sv =====
// APB-style configuration registers.
module svpg_cfg import svpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length <= FRAME_LENGTH_RST;
      cfg_r.min_width    <= MIN_WIDTH_RST;
      cfg_r.width_span   <= WIDTH_SPAN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_LENGTH: cfg_r.frame_length <= pwdata[FRAME_W-1:0];
        REG_MIN_WIDTH:    cfg_r.min_width    <= pwdata[SAMPLE_W-1:0];
        REG_WIDTH_SPAN:   cfg_r.width_span   <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_LENGTH: prdata = CFG_DATA_W'(cfg_r.frame_length);
      REG_MIN_WIDTH:    prdata = CFG_DATA_W'(cfg_r.min_width);
      REG_WIDTH_SPAN:   prdata = CFG_DATA_W'(cfg_r.width_span);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== design/svpg_width.sv =====
// Pulse width from a sample: sample*span/255 + min_width.
module svpg_width import svpg_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] span,
  input  logic [SAMPLE_W-1:0] min_width,
  output logic [WIDTH_W-1:0]  width
);

  logic [2*SAMPLE_W-1:0] prod;
  logic [2*SAMPLE_W:0]   acc;
  logic [SAMPLE_W-1:0]   quot;

  // x/255 == (x + (x>>8) + 1) >> 8, exact for x up to 255*255
  assign prod  = (2*SAMPLE_W)'(sample) * (2*SAMPLE_W)'(span);
  assign acc   = (2*SAMPLE_W+1)'(prod) + (2*SAMPLE_W+1)'(prod >> SAMPLE_W)
               + (2*SAMPLE_W+1)'(1);
  assign quot  = acc[2*SAMPLE_W-1:SAMPLE_W];
  assign width = WIDTH_W'(quot) + WIDTH_W'(min_width);

endmodule

// ===== design/svpg_core.sv =====
// Servo sequencer state: sample store, channel pointer, frame and pulse timing.
module svpg_core import svpg_pkg::*; #(
  parameter int NUM_SERVOS = 3
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int SERVO_W = $clog2(NUM_SERVOS + 1);
  localparam int CH_W    = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [SERVO_W-1:0] IDLE       = SERVO_W'(NUM_SERVOS);
  localparam logic [SERVO_W-1:0] LAST_SERVO = SERVO_W'(NUM_SERVOS - 1);
  localparam logic [CH_W-1:0]    LAST_CH    = CH_W'(NUM_SERVOS - 1);

  logic [SAMPLE_W-1:0] samples_r [NUM_SERVOS];
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [SERVO_W-1:0]  active_r, active_nxt, act_mid, begin_servo;
  logic [WIDTH_W-1:0]  pc_r, pc_nxt, pc_inc, pw_r, pw_nxt, new_width;
  logic [FRAME_W-1:0]  fc_r, fc_nxt, fc_inc;
  logic                pend_r, pend_nxt;
  logic                ev, do_begin, started;
  logic [2:0]          pins;

  svpg_width u_width (
    .sample    (samples_r[begin_servo[CH_W-1:0]]),
    .span      (cfg.width_span),
    .min_width (cfg.min_width),
    .width     (new_width)
  );

  always_comb begin
    ch_nxt      = ch_r;
    active_nxt  = active_r;
    act_mid     = active_r;
    begin_servo = '0;
    pc_nxt      = pc_r;
    pw_nxt      = pw_r;
    fc_nxt      = fc_r;
    pend_nxt    = pend_r;
    pc_inc      = pc_r + WIDTH_W'(1);
    fc_inc      = fc_r + FRAME_W'(1);
    ev          = 1'b0;
    do_begin    = 1'b0;
    started     = 1'b0;
    if (item.req_type == REQ_SAMPLE) begin
      ch_nxt = (ch_r == LAST_CH) ? '0 : ch_r + CH_W'(1);
    end else begin
      // advance the running pulse; hand over to the next servo or go idle
      if (active_r != IDLE) begin
        pc_nxt = pc_inc;
        if (pc_inc > pw_r) begin
          if (active_r != LAST_SERVO) begin
            act_mid     = active_r + SERVO_W'(1);
            begin_servo = act_mid;
            do_begin    = 1'b1;
          end else begin
            act_mid = IDLE;
          end
        end
      end
      ev     = (fc_inc >= cfg.frame_length);
      fc_nxt = ev ? '0 : fc_inc;
      // frames that elapse while busy collapse into one pending start
      if (act_mid == IDLE) begin
        if (ev || pend_r) begin
          pend_nxt    = 1'b0;
          begin_servo = '0;
          do_begin    = 1'b1;
          started     = 1'b1;
        end
      end else if (ev) begin
        pend_nxt = 1'b1;
      end
      if (do_begin) begin
        active_nxt = begin_servo;
        pc_nxt     = '0;
        pw_nxt     = new_width;
      end else begin
        active_nxt = act_mid;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pins[i] = (i < NUM_SERVOS) && (active_nxt == SERVO_W'(i));
    end
  end

  assign result.servo_pins  = pins;
  assign result.adc_channel = 2'(ch_nxt);
  assign result.frame_start = started;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r     <= '0;
      active_r <= IDLE;
      pc_r     <= '0;
      pw_r     <= '0;
      fc_r     <= '0;
      pend_r   <= 1'b0;
    end else if (step_en) begin
      ch_r     <= ch_nxt;
      active_r <= active_nxt;
      pc_r     <= pc_nxt;
      pw_r     <= pw_nxt;
      fc_r     <= fc_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        samples_r[i] <= '0;
      end
    end else if (step_en && item.req_type == REQ_SAMPLE) begin
      samples_r[ch_r] <= item.sample;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the three-channel servo pulse generator.
module tb_top import svpg_pkg::*; ();

  // Servo count of this build; the predictor tracks the same number of channels.
  localparam int SERVO_COUNT = 3;
  // Cycles with no request, result or register access before the run is given up.
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 310;

  // Directed table: a row is either a register write or one request.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One request waiting to go out. Where 'typed' is set, 'want' is the result
  // read straight off the spec; otherwise the predictor supplies it.
  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } queued_request_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [FRAME_W-1:0]   reg_val;
    item_t               it;
    logic                typed;
    result_t             want;
  } directed_row_t;

  // Reset state first, then short (zero-width) pulses with a frame event on
  // every tick, then maximal widths, then the longest frame.
  localparam directed_row_t DIRECTED_ROWS [0:25] = '{
    // reset config: samples fill channels 0,1,2 and the converter pointer wraps
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd255}, 1'b1, '{3'b000, 2'd1, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd0},   1'b1, '{3'b000, 2'd2, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd170}, 1'b1, '{3'b000, 2'd0, 1'b0}},
    // one tick, frame of 2000 far away
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b1, '{3'b000, 2'd0, 1'b0}},
    // frame length zero: every tick is a frame event; zero width pulses
    '{ROW_CFG,  REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    '{ROW_CFG,  REG_MIN_WIDTH,    16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    '{ROW_CFG,  REG_WIDTH_SPAN,   16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b1, '{3'b001, 2'd0, 1'b1}},
    // frames while busy fold into one pending start
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b1, '{3'b010, 2'd0, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd5},     1'b1, '{3'b100, 2'd0, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd255},   1'b1, '{3'b001, 2'd0, 1'b1}},
    // a sample in mid sequence is stored, pulses unaffected
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd7},   1'b1, '{3'b001, 2'd1, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b1, '{3'b010, 2'd1, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b1, '{3'b100, 2'd1, 1'b0}},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b1, '{3'b001, 2'd1, 1'b1}},
    // frame length one, widest pulses (255 + 255)
    '{ROW_CFG,  REG_FRAME_LENGTH, 16'd1,   '{REQ_TICK, 8'd0},   1'b0, '0},
    '{ROW_CFG,  REG_MIN_WIDTH,    16'd255, '{REQ_TICK, 8'd0},   1'b0, '0},
    '{ROW_CFG,  REG_WIDTH_SPAN,   16'd255, '{REQ_TICK, 8'd0},   1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd255}, 1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd255}, 1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    // longest frame
    '{ROW_CFG,  REG_FRAME_LENGTH, 16'd65535, '{REQ_TICK, 8'd0}, 1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_TICK, 8'd0},     1'b0, '0},
    '{ROW_ITEM, REG_FRAME_LENGTH, 16'd0, '{REQ_SAMPLE, 8'd1},   1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  svpg_in_if  in_chan ();
  svpg_out_if out_chan ();

  three_channel_servo_pulse_generator_unit #(
    .NUM_SERVOS(SERVO_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Servo predictor: its own copy of the registers and sequencer state.
  // --------------------------------------------------------------------------
  cfg_t        model_cfg;
  logic [7:0]  held_samples [SERVO_COUNT];
  int unsigned adc_ptr;
  int unsigned active_servo;    // SERVO_COUNT means no pulse running
  logic [8:0]  pulse_ticks;
  logic [8:0]  pulse_len;
  logic [15:0] frame_ticks;
  bit          frame_owed;

  // Width is taken from the stored sample at the moment the pulse begins.
  function automatic void latch_pulse(int unsigned servo);
    int unsigned s;
    int unsigned w;
    s = held_samples[servo];
    w = (s * model_cfg.width_span) / 255 + model_cfg.min_width;
    active_servo = servo;
    pulse_ticks  = '0;
    pulse_len    = w[8:0];
  endfunction

  function automatic result_t compute_servo_outputs(item_t it);
    result_t r;
    bit      frame_evt;
    bit      started;
    frame_evt = 1'b0;
    started   = 1'b0;
    if (it.req_type == REQ_SAMPLE) begin
      // samples store the value and move the converter pointer; no pulse activity
      held_samples[adc_ptr] = it.sample;
      adc_ptr = (adc_ptr + 1 >= SERVO_COUNT) ? 0 : adc_ptr + 1;
    end else begin
      // running pulse first: may hand over to the next servo on this tick
      if (active_servo < SERVO_COUNT) begin
        pulse_ticks = pulse_ticks + 9'd1;
        if (pulse_ticks > pulse_len) begin
          if (active_servo + 1 < SERVO_COUNT) latch_pulse(active_servo + 1);
          else active_servo = SERVO_COUNT;
        end
      end
      // then the frame counter; frame length 0 or 1 fires every tick
      frame_ticks = frame_ticks + 16'd1;
      if (frame_ticks >= model_cfg.frame_length) begin
        frame_ticks = '0;
        frame_evt   = 1'b1;
      end
      if (active_servo >= SERVO_COUNT) begin
        if (frame_evt || frame_owed) begin
          frame_owed = 1'b0;
          latch_pulse(0);
          started = 1'b1;
        end
      end else if (frame_evt) begin
        frame_owed = 1'b1;    // several busy frames collapse into one
      end
    end
    r.servo_pins  = (active_servo < 3) ? 3'(1 << active_servo) : 3'b000;
    r.adc_channel = adc_ptr[1:0];
    r.frame_start = started;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request / result traffic
  // --------------------------------------------------------------------------
  queued_request_t outgoing_requests[$];
  result_t         expected_outputs[$];
  queued_request_t held;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              mismatches;
  int              quiet_cycles;

  task automatic check_field(string field, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
      mismatches++;
    end
  endtask

  function automatic bit requests_in_flight();
    return outgoing_requests.size() != 0 || in_chan.valid || expected_outputs.size() != 0;
  endfunction

  // Input side is handled before the output side so a same-edge result
  // always finds its expectation already queued.
  always @(posedge clk) begin : traffic
    result_t predicted;
    result_t want;
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      out_chan.ready <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predicted = compute_servo_outputs(held.it);
        expected_outputs.push_back(held.typed ? held.want : predicted);
      end
      // one assignment to valid per edge: either the next request or idle
      if (!in_chan.valid || in_chan.ready) begin
        if (outgoing_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held             = outgoing_requests.pop_front();
          in_chan.valid    <= 1'b1;
          in_chan.req_type <= held.it.req_type;
          in_chan.sample   <= held.it.sample;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end

      if (out_chan.valid && out_chan.ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pins %0d ch %0d start %0d",
                   $time, out_chan.servo_pins, out_chan.adc_channel, out_chan.frame_start);
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("servo_pins",  want.servo_pins,  out_chan.servo_pins);
          check_field("adc_channel", want.adc_channel, out_chan.adc_channel);
          check_field("frame_start", want.frame_start, out_chan.frame_start);
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any request, result or register access counts as progress.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Register write followed by a readback, only once the pipeline has drained.
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(val);
    do @(negedge clk); while (requests_in_flight());
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FRAME_LENGTH: model_cfg.frame_length = val;
      REG_MIN_WIDTH:    model_cfg.min_width    = val[7:0];
      REG_WIDTH_SPAN:   model_cfg.width_span   = val[7:0];
      default: ;
    endcase
    // back-to-back read of the same register
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== word) begin
      $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
               $time, idx, word, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases.
  // --------------------------------------------------------------------------
  initial begin
    queued_request_t rq;
    logic [15:0]     fl;
    logic [7:0]      mw;
    logic [7:0]      ws;

    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_chan.valid    = 1'b0;
    in_chan.req_type = REQ_SAMPLE;
    in_chan.sample   = '0;
    out_chan.ready   = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatches       = 0;
    quiet_cycles     = 0;

    model_cfg.frame_length = FRAME_LENGTH_RST;
    model_cfg.min_width    = MIN_WIDTH_RST;
    model_cfg.width_span   = WIDTH_SPAN_RST;
    foreach (held_samples[i]) held_samples[i] = '0;
    adc_ptr      = 0;
    active_servo = SERVO_COUNT;
    pulse_ticks  = '0;
    pulse_len    = '0;
    frame_ticks  = '0;
    frame_owed   = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        program_register(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].reg_val);
      end else begin
        rq.it    = DIRECTED_ROWS[i].it;
        rq.typed = DIRECTED_ROWS[i].typed;
        rq.want  = DIRECTED_ROWS[i].want;
        outgoing_requests.push_back(rq);
      end
    end

    // random phases; widths and frames mostly kept short so sequences turn over often
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          fl = 16'd30; mw = 8'd4; ws = 8'd20;
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          fl = 16'd0; mw = 8'd0; ws = 8'd0;
          send_idle_pct = 74; recv_stall_pct = 0;
        end
        2: begin
          fl = 16'($urandom_range(2, 60)); mw = 8'($urandom_range(0, 15));
          ws = 8'($urandom_range(0, 40));
          send_idle_pct = 0; recv_stall_pct = 74;
        end
        3: begin
          fl = 16'($urandom_range(0, 40)); mw = 8'($urandom_range(1, 10));
          ws = 8'($urandom_range(0, 255));
          send_idle_pct = 37; recv_stall_pct = 37;
        end
        4: begin
          // widest pulses against a frame on every tick
          fl = 16'd1; mw = 8'd255; ws = 8'd255;
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        default: begin
          fl = 16'($urandom_range(0, 80)); mw = 8'($urandom_range(0, 30));
          ws = 8'($urandom_range(0, 255));
          send_idle_pct = 37; recv_stall_pct = 37;
        end
      endcase
      program_register(REG_FRAME_LENGTH, fl);
      program_register(REG_MIN_WIDTH, 16'(mw));
      program_register(REG_WIDTH_SPAN, 16'(ws));

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        rq.typed = 1'b0;
        rq.want  = '0;
        if ($urandom_range(99) < 22) begin
          rq.it.req_type = REQ_SAMPLE;
          if ($urandom_range(3) == 0) rq.it.sample = $urandom_range(1) ? 8'hFF : 8'h00;
          else rq.it.sample = 8'($urandom_range(255));
        end else begin
          // sample field is don't-care on ticks; keep it toggling anyway
          rq.it.req_type = REQ_TICK;
          rq.it.sample   = 8'($urandom_range(255));
        end
        outgoing_requests.push_back(rq);
      end
    end

    do @(negedge clk); while (requests_in_flight());
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
